// ===== hdl/iff_pkg.sv =====
// Package for the integer field formatter: payload structs, internal stage
// types, character and conversion codes. No dependencies.
`default_nettype none
package iff_pkg;

  localparam int DIGIT_BUFFER_LEN = 12;
  localparam int VALUE_W          = 32;
  localparam int BCD_W            = 40;
  localparam int DABBLE_STAGES    = 8;
  localparam int DABBLE_STEPS     = VALUE_W / DABBLE_STAGES;
  localparam int NIB_W            = 4 * DIGIT_BUFFER_LEN;
  localparam int LEN_W            = $clog2(DIGIT_BUFFER_LEN + 1);
  localparam int IDX_W            = $clog2(DIGIT_BUFFER_LEN);
  localparam int FW_W             = 6;

  localparam logic [1:0] CONV_SDEC = 2'd0;
  localparam logic [1:0] CONV_UDEC = 2'd1;
  localparam logic [1:0] CONV_LHEX = 2'd2;
  localparam logic [1:0] CONV_UHEX = 2'd3;

  localparam int PAD_RIGHT_BIT = 0;
  localparam int PAD_ZERO_BIT  = 1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         conversion;
    logic [FW_W-1:0]    field_width;
    logic [1:0]         pad_mode;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0]   bcd;
    logic               neg;
    logic [1:0]         conversion;
    logic [FW_W-1:0]    field_width;
    logic [1:0]         pad_mode;
  } work_t;

  typedef struct packed {
    logic [DIGIT_BUFFER_LEN-1:0][7:0] chars;
    logic [IDX_W-1:0]                 top_idx;
    logic                             lead_minus;
    logic [FW_W-1:0]                  pad_cnt;
    logic                             trail_pad;
    logic [7:0]                       pad_char;
  } fmt_t;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_SIGN,
    EM_PADL,
    EM_DIGS,
    EM_PADR
  } emit_state_t;

endpackage
`default_nettype wire

// ===== hdl/iff_conv.sv =====
// Conversion pipeline: magnitude, double-dabble stages and the digit string
// format stage. Depends on iff_pkg.
`default_nettype none
module iff_conv (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire iff_pkg::in_t  in_data,
  output logic               fmt_valid,
  input  wire logic          fmt_ready,
  output iff_pkg::fmt_t      fmt_data
);

  localparam int NST = iff_pkg::DABBLE_STAGES + 1;

  logic [NST-1:0]       valid_r;
  logic [NST-1:0]       stg_rdy;
  iff_pkg::work_t       work_r   [NST];
  iff_pkg::work_t       work_nxt [NST];
  logic                 fv_r;
  logic                 fmt_rdy;
  iff_pkg::fmt_t        fmt_r;
  iff_pkg::fmt_t        fmt_nxt;

  assign fmt_rdy  = !fv_r || fmt_ready;
  assign in_ready = stg_rdy[0];

  always_comb begin
    stg_rdy[NST-1] = !valid_r[NST-1] || fmt_rdy;
    for (int s = NST - 2; s >= 0; s--) begin
      stg_rdy[s] = !valid_r[s] || stg_rdy[s+1];
    end
  end

  always_comb begin
    logic                      neg;
    logic [iff_pkg::BCD_W-1:0] b;
    neg = (in_data.conversion == iff_pkg::CONV_SDEC) && in_data.value[iff_pkg::VALUE_W-1];
    work_nxt[0].neg         = neg;
    work_nxt[0].mag         = neg ? (~in_data.value + 1'b1) : in_data.value;
    work_nxt[0].bcd         = '0;
    work_nxt[0].conversion  = in_data.conversion;
    work_nxt[0].field_width = in_data.field_width;
    work_nxt[0].pad_mode    = in_data.pad_mode;
    for (int s = 1; s < NST; s++) begin
      b = work_r[s-1].bcd;
      for (int j = 0; j < iff_pkg::DABBLE_STEPS; j++) begin
        for (int k = 0; k < iff_pkg::BCD_W / 4; k++) begin
          if (b[4*k +: 4] >= 4'd5) begin
            b[4*k +: 4] = b[4*k +: 4] + 4'd3;
          end
        end
        b = {b[iff_pkg::BCD_W-2:0],
             work_r[s-1].mag[iff_pkg::VALUE_W-1-((s-1)*iff_pkg::DABBLE_STEPS+j)]};
      end
      work_nxt[s]     = work_r[s-1];
      work_nxt[s].bcd = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stg_rdy[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (stg_rdy[s]) begin
          valid_r[s] <= valid_r[s-1];
        end
      end
    end
    if (stg_rdy[0] && in_valid) begin
      work_r[0] <= work_nxt[0];
    end
    for (int s = 1; s < NST; s++) begin
      if (stg_rdy[s] && valid_r[s-1]) begin
        work_r[s] <= work_nxt[s];
      end
    end
  end

  always_comb begin
    iff_pkg::work_t           w;
    logic [iff_pkg::NIB_W-1:0] nib;
    logic                     hex;
    logic [7:0]               letter;
    logic [3:0]               d;
    logic [iff_pkg::LEN_W-1:0] ndig;
    logic [iff_pkg::LEN_W-1:0] len;
    logic                     lead;
    logic                     inline_minus;
    logic [iff_pkg::FW_W-1:0] w2;
    w      = work_r[NST-1];
    hex    = w.conversion[1];
    letter = (w.conversion == iff_pkg::CONV_UHEX) ? iff_pkg::CH_UP_A : iff_pkg::CH_LOW_A;
    nib    = hex ? iff_pkg::NIB_W'(w.mag) : iff_pkg::NIB_W'(w.bcd);
    ndig   = iff_pkg::LEN_W'(1);
    for (int k = 0; k < iff_pkg::DIGIT_BUFFER_LEN; k++) begin
      if (nib[4*k +: 4] != 4'd0) begin
        ndig = iff_pkg::LEN_W'(k + 1);
      end
    end
    lead         = w.neg && (w.field_width != '0) && w.pad_mode[iff_pkg::PAD_ZERO_BIT];
    inline_minus = w.neg && !lead;
    len          = ndig + iff_pkg::LEN_W'(inline_minus);
    for (int k = 0; k < iff_pkg::DIGIT_BUFFER_LEN; k++) begin
      d = nib[4*k +: 4];
      if (iff_pkg::LEN_W'(k) < ndig) begin
        fmt_nxt.chars[k] = (d < 4'd10) ? (iff_pkg::CH_ZERO + {4'b0, d})
                                       : (letter + {4'b0, d} - 8'd10);
      end else if (iff_pkg::LEN_W'(k) == ndig && inline_minus) begin
        fmt_nxt.chars[k] = iff_pkg::CH_MINUS;
      end else begin
        fmt_nxt.chars[k] = iff_pkg::CH_SPACE;
      end
    end
    w2 = w.field_width - iff_pkg::FW_W'(lead);
    fmt_nxt.top_idx    = iff_pkg::IDX_W'(len - 1'b1);
    fmt_nxt.lead_minus = lead;
    fmt_nxt.pad_cnt    = (w2 > iff_pkg::FW_W'(len)) ? (w2 - iff_pkg::FW_W'(len)) : '0;
    fmt_nxt.trail_pad  = w.pad_mode[iff_pkg::PAD_RIGHT_BIT];
    fmt_nxt.pad_char   = w.pad_mode[iff_pkg::PAD_ZERO_BIT] ? iff_pkg::CH_ZERO
                                                           : iff_pkg::CH_SPACE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (fmt_rdy) begin
      fv_r <= valid_r[NST-1];
    end
    if (fmt_rdy && valid_r[NST-1]) begin
      fmt_r <= fmt_nxt;
    end
  end

  assign fmt_valid = fv_r;
  assign fmt_data  = fmt_r;

endmodule
`default_nettype wire

// ===== hdl/iff_emit.sv =====
// Character sequencer: walks sign, pad and digit string of one field into
// the output register. Depends on iff_pkg.
`default_nettype none
module iff_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fmt_valid,
  output logic                fmt_ready,
  input  wire iff_pkg::fmt_t  fmt_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output iff_pkg::out_t       out_data
);

  iff_pkg::emit_state_t             state_r;
  iff_pkg::emit_state_t             state_nxt;
  iff_pkg::emit_state_t             first_state;
  logic [iff_pkg::DIGIT_BUFFER_LEN-1:0][7:0] chars_r;
  logic [iff_pkg::IDX_W-1:0]        idx_r;
  logic [iff_pkg::FW_W-1:0]         cnt_r;
  logic                             trail_pad_r;
  logic [7:0]                       pad_char_r;
  logic                             out_valid_r;
  iff_pkg::out_t                    out_r;
  logic                             adv;
  logic                             load;
  logic [7:0]                       cur_char;
  logic                             cur_last;

  assign adv       = (state_r != iff_pkg::EM_IDLE) && (!out_valid_r || out_ready);
  assign fmt_ready = (state_r == iff_pkg::EM_IDLE) || (adv && cur_last);
  assign load      = fmt_valid && fmt_ready;

  always_comb begin
    case (state_r)
      iff_pkg::EM_SIGN: begin
        cur_char = iff_pkg::CH_MINUS;
        cur_last = 1'b0;
      end
      iff_pkg::EM_PADL: begin
        cur_char = pad_char_r;
        cur_last = 1'b0;
      end
      iff_pkg::EM_DIGS: begin
        cur_char = chars_r[idx_r];
        cur_last = (idx_r == '0) && !(trail_pad_r && cnt_r != '0);
      end
      iff_pkg::EM_PADR: begin
        cur_char = pad_char_r;
        cur_last = (cnt_r == iff_pkg::FW_W'(1));
      end
      default: begin
        cur_char = iff_pkg::CH_SPACE;
        cur_last = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (fmt_data.lead_minus) begin
      first_state = iff_pkg::EM_SIGN;
    end else if (!fmt_data.trail_pad && fmt_data.pad_cnt != '0) begin
      first_state = iff_pkg::EM_PADL;
    end else begin
      first_state = iff_pkg::EM_DIGS;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (load) begin
      state_nxt = first_state;
    end else if (adv) begin
      case (state_r)
        iff_pkg::EM_SIGN: begin
          state_nxt = (!trail_pad_r && cnt_r != '0) ? iff_pkg::EM_PADL : iff_pkg::EM_DIGS;
        end
        iff_pkg::EM_PADL: begin
          state_nxt = (cnt_r == iff_pkg::FW_W'(1)) ? iff_pkg::EM_DIGS : iff_pkg::EM_PADL;
        end
        iff_pkg::EM_DIGS: begin
          if (idx_r == '0) begin
            state_nxt = (trail_pad_r && cnt_r != '0) ? iff_pkg::EM_PADR : iff_pkg::EM_IDLE;
          end
        end
        iff_pkg::EM_PADR: begin
          state_nxt = (cnt_r == iff_pkg::FW_W'(1)) ? iff_pkg::EM_IDLE : iff_pkg::EM_PADR;
        end
        default: begin
          state_nxt = iff_pkg::EM_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iff_pkg::EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars_r     <= fmt_data.chars;
      idx_r       <= fmt_data.top_idx;
      cnt_r       <= fmt_data.pad_cnt;
      trail_pad_r <= fmt_data.trail_pad;
      pad_char_r  <= fmt_data.pad_char;
    end else if (adv) begin
      if (state_r == iff_pkg::EM_PADL || state_r == iff_pkg::EM_PADR) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (state_r == iff_pkg::EM_DIGS && idx_r != '0) begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv) begin
      out_r.char_out  <= cur_char;
      out_r.last_char <= cur_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== hdl/integer_field_formatter.sv =====
// Top level of the integer field formatter: conversion pipeline followed by
// the character sequencer. Depends on iff_pkg, iff_conv and iff_emit.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   in_      | input     | in_valid / in_ready  | iff_pkg::in_t  (one field)
//   out_     | output    | out_valid / out_ready| iff_pkg::out_t (one char)
//
// A field leaves as max(field_width, digits plus sign) characters, one per
// cycle while out_ready is high, so one transaction spans 1 to 63 characters,
// all emitted by the character sequencer. A field passes the input register,
// the dabble stages, the format stage and the output register in that order.
// Reset is synchronous and clears all valid bits and the sequencer state.
// A low out_ready holds the output register and back-pressures every stage.
`default_nettype none
module integer_field_formatter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire iff_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output iff_pkg::out_t      out_data
);

  logic          fmt_valid;
  logic          fmt_ready;
  iff_pkg::fmt_t fmt_data;

  iff_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fmt_valid (fmt_valid),
    .fmt_ready (fmt_ready),
    .fmt_data  (fmt_data)
  );

  iff_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt_valid (fmt_valid),
    .fmt_ready (fmt_ready),
    .fmt_data  (fmt_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/iff_chk.sv =====
// Port-level checker for the integer field formatter and its bind statement.
// Depends on iff_pkg and integer_field_formatter.
`default_nettype none
module iff_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire iff_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire iff_pkg::out_t out_data
);

  logic [4:0] pending_r;
  logic [4:0] pending_nxt;
  logic       in_acc;
  logic       out_end;
  logic [7:0] c;

  assign in_acc  = in_valid && in_ready;
  assign out_end = out_valid && out_ready && out_data.last_char;
  assign c       = out_data.char_out;

  always_comb begin
    pending_nxt = pending_r + 5'(in_acc) - 5'(out_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("character without an open field");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((c >= iff_pkg::CH_ZERO && c <= 8'h39) ||
                   (c >= iff_pkg::CH_LOW_A && c <= 8'h66) ||
                   (c >= iff_pkg::CH_UP_A && c <= 8'h46) ||
                   c == iff_pkg::CH_MINUS || c == iff_pkg::CH_SPACE))
    else $error("character outside the formatter alphabet");

endmodule

bind integer_field_formatter iff_chk u_iff_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
